### hdl/d2i_pkg.sv
package d2i_pkg;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
   localparam logic [10:0] EXP_BIAS     = 11'd1023;
   localparam logic [10:0] EXP_SAT      = 11'd1086;
   localparam logic [10:0] EXP_SHL      = 11'd1075;
   localparam logic [1:0]  TAG_INT      = 2'd0;
   localparam logic [1:0]  TAG_FLOAT    = 2'd1;
   localparam logic [1:0]  FUNC_I32     = 2'd0;

   // result classes decided in stage one
   typedef enum logic [1:0] {
      CLS_ZERO  = 2'd0,
      CLS_SHIFT = 2'd1,
      CLS_SAT   = 2'd2,
      CLS_PASS  = 2'd3
   } cls_type;
endpackage

### hdl/double_to_integer_converter.sv
// A request passes through the stage one, two and three registers to rsp valid.
// Throughput: one item per cycle; the three-stage pipeline advances as one
// unit whenever the output stage is empty or being taken.
// Reset: synchronous, active high; clears the stage valid bits only.
module double_to_integer_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_tag,
   input  logic [63:0] req_float_bits,
   input  logic signed [31:0] req_int_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [63:0] rsp_value,
   output logic        rsp_error
);
   logic advance;
   logic v1_ff, v2_ff, v3_ff;

   // stage one registers
   d2i_pkg::cls_type cls1_ff, cls1_in;
   logic        neg1_ff, err1_ff, i32_1_ff, left1_ff;
   logic [52:0] mant1_ff;
   logic [5:0]  sh1_ff, sh1_in;
   logic [31:0] ip1_ff;

   // stage two registers
   logic [63:0] mag2_ff, mag2_in;
   d2i_pkg::cls_type cls2_ff;
   logic        neg2_ff, err2_ff, i32_2_ff;
   logic [31:0] ip2_ff;

   // stage three registers
   logic [63:0] val3_ff, val3_in;
   logic        err3_ff;

   logic [10:0] e;
   logic        mant_nz;
   logic [11:0] rsh;
   logic [11:0] lsh;

   assign advance   = !v3_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = v3_ff;
   assign rsp_value = val3_ff;
   assign rsp_error = err3_ff;

   // classify and compute the shift amount
   always_comb begin
      e       = req_float_bits[62:52];
      mant_nz = req_float_bits[51:0] != 52'd0;
      rsh     = {1'b0, d2i_pkg::EXP_SHL} - {1'b0, e};
      lsh     = {1'b0, e} - {1'b0, d2i_pkg::EXP_SHL};
      cls1_in = d2i_pkg::CLS_SHIFT;
      sh1_in  = 6'd0;
      if (req_tag == d2i_pkg::TAG_INT) begin
         cls1_in = d2i_pkg::CLS_PASS;
      end else if (req_tag != d2i_pkg::TAG_FLOAT) begin
         cls1_in = d2i_pkg::CLS_ZERO;
      end else if (req_func[1]) begin
         if (e == d2i_pkg::EXP_ALL_ONES && mant_nz) cls1_in = d2i_pkg::CLS_ZERO;
         else if (e >= d2i_pkg::EXP_SAT) cls1_in = d2i_pkg::CLS_SAT;
      end else if (e == d2i_pkg::EXP_ALL_ONES) begin
         cls1_in = d2i_pkg::CLS_ZERO;
      end
      if (cls1_in == d2i_pkg::CLS_SHIFT) begin
         if (e < d2i_pkg::EXP_BIAS) cls1_in = d2i_pkg::CLS_ZERO;
         else if (e >= d2i_pkg::EXP_SHL) begin
            if (lsh >= 12'd64) cls1_in = d2i_pkg::CLS_ZERO;
            else sh1_in = lsh[5:0];
         end else sh1_in = rsh[5:0];
      end
   end

   // shift the mantissa into place
   always_comb begin
      if (left1_ff) mag2_in = {11'd0, mant1_ff} << sh1_ff;
      else          mag2_in = {11'd0, mant1_ff} >> sh1_ff;
   end

   // apply sign, width and saturation, or select zero or the integer payload
   always_comb begin
      logic [63:0] r;
      r = neg2_ff ? (64'd0 - mag2_ff) : mag2_ff;
      if (i32_2_ff) r = {{32{r[31]}}, r[31:0]};
      case (cls2_ff)
         d2i_pkg::CLS_ZERO:  val3_in = 64'd0;
         d2i_pkg::CLS_SAT:   val3_in = neg2_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         d2i_pkg::CLS_PASS:  val3_in = {{32{ip2_ff[31]}}, ip2_ff};
         d2i_pkg::CLS_SHIFT: val3_in = r;
         default:            val3_in = 64'd0;
      endcase
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         cls1_ff  <= cls1_in;
         sh1_ff   <= sh1_in;
         left1_ff <= req_float_bits[62:52] >= d2i_pkg::EXP_SHL;
         mant1_ff <= {1'b1, req_float_bits[51:0]};
         neg1_ff  <= req_float_bits[63];
         err1_ff  <= req_tag != d2i_pkg::TAG_INT && req_tag != d2i_pkg::TAG_FLOAT;
         i32_1_ff <= req_func == d2i_pkg::FUNC_I32;
         ip1_ff   <= req_int_payload;
         mag2_ff  <= mag2_in;
         cls2_ff  <= cls1_ff;
         neg2_ff  <= neg1_ff;
         err2_ff  <= err1_ff;
         i32_2_ff <= i32_1_ff;
         ip2_ff   <= ip1_ff;
         val3_ff  <= val3_in;
         err3_ff  <= err2_ff;
      end
   end
endmodule

### dv/double_to_integer_converter_tb.sv
module double_to_integer_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_I64_WRAP = 2'd1;
   localparam logic [1:0] FUNC_I64_SAT  = 2'd2;
   localparam logic [1:0] FUNC_SPARE    = 2'd3;
   localparam logic [1:0] TAG_EXC       = 2'd2;
   localparam logic [1:0] TAG_SPARE     = 2'd3;
   localparam int         LIMIT_CYCLES  = 200000;
   localparam int         RANDOM_ITEMS  = 1076;

   // Expected conversion results, oldest first, and the checks on them
   class conversion_scoreboard;
      logic [63:0] value_q[$];
      logic        error_q[$];
      int          fails;

      // truncated magnitude of a binary64 pattern, modulo 2^64
      function logic [63:0] magnitude(logic [63:0] bits);
         logic [10:0] e;
         logic [63:0] m;
         int          sh;
         e = bits[62:52];
         m = {11'd0, 1'b1, bits[51:0]};
         if (e < d2i_pkg::EXP_BIAS) return 64'd0;
         if (e >= 11'd1075) begin
            sh = int'(e) - 1075;
            if (sh >= 64) return 64'd0;
            return m << sh;
         end
         return m >> (1075 - int'(e));
      endfunction

      function logic [63:0] from_double(logic [1:0] func, logic [63:0] bits);
         logic [10:0] e;
         logic [63:0] r;
         e = bits[62:52];
         if (func[1]) begin
            if (e == d2i_pkg::EXP_ALL_ONES && bits[51:0] != 0) return 64'd0;
            if (e >= d2i_pkg::EXP_SAT) return bits[63] ? 64'h8000_0000_0000_0000
                                                       : 64'h7fff_ffff_ffff_ffff;
            r = magnitude(bits);
            return bits[63] ? -r : r;
         end
         if (e == d2i_pkg::EXP_ALL_ONES) return 64'd0;
         r = magnitude(bits);
         if (bits[63]) r = -r;
         if (func == d2i_pkg::FUNC_I32) r = {{32{r[31]}}, r[31:0]};
         return r;
      endfunction

      function void note_request(logic [1:0] func, logic [1:0] tag,
                                 logic [63:0] fbits, logic [31:0] ival);
         if (tag == d2i_pkg::TAG_INT) begin
            value_q.push_back({{32{ival[31]}}, ival});
            error_q.push_back(1'b0);
         end else if (tag == d2i_pkg::TAG_FLOAT) begin
            value_q.push_back(from_double(func, fbits));
            error_q.push_back(1'b0);
         end else begin
            value_q.push_back(64'd0);
            error_q.push_back(1'b1);
         end
      endfunction

      function void check_response(logic [63:0] value, logic error);
         logic [63:0] ev;
         logic        ee;
         if (value_q.size() == 0) begin
            $error("unexpected response value=%h error=%b", value, error);
            fails++;
            return;
         end
         ev = value_q.pop_front();
         ee = error_q.pop_front();
         if (value !== ev) begin
            $error("value: expected %h, got %h", ev, value);
            fails++;
         end
         if (error !== ee) begin
            $error("error: expected %b, got %b", ee, error);
            fails++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_func, req_tag;
   logic [63:0] req_float_bits;
   logic signed [31:0] req_int_payload;
   logic        rsp_valid, rsp_stall;
   logic signed [63:0] rsp_value;
   logic        rsp_error;

   conversion_scoreboard sb = new();
   bit  stimulus_done;
   bit  hold_off_req;
   int  cycles;

   double_to_integer_converter i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // note requests and check responses at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_func, req_tag, req_float_bits, req_int_payload);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_value, rsp_error);
   end

   // drive one request and hold it until the transfer; valid stays high afterwards
   task automatic send(logic [1:0] func, logic [1:0] tag, logic [63:0] fbits,
                       logic [31:0] ival);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_tag         <= tag;
      req_float_bits  <= fbits;
      req_int_payload <= ival;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [63:0] dbl(bit s, int e, logic [51:0] m);
      return {s, 11'(e), m};
   endfunction

   function automatic logic [63:0] random_double();
      int e;
      case ($urandom_range(0, 5))
         0: e = $urandom_range(0, 2047);
         1: e = $urandom_range(1023, 1023 + 31);
         2: e = $urandom_range(1023 + 28, 1023 + 66);
         3: e = $urandom_range(1023 + 60, 1023 + 118);
         4: e = $urandom_range(1020, 1023 + 55);
         default: e = $urandom_range(0, 1) ? 2047 : $urandom_range(0, 3);
      endcase
      return dbl($urandom_range(0, 1), e, 52'({$urandom, $urandom}));
   endfunction

   // receiver: random stall per cycle, one long hold-off on request
   initial begin
      int wait_n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (1) begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (40) @(negedge clock);
            hold_off_req = 0;
         end
         wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
         rsp_stall <= wait_n != 0;
         repeat (wait_n > 0 ? wait_n : 1) @(negedge clock);
         if (wait_n != 0) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
      end
   end

   initial begin
      logic [1:0] f, t;
      logic [63:0] special[$];
      req_valid = 0; req_func = d2i_pkg::FUNC_I32; req_tag = d2i_pkg::TAG_INT;
      req_float_bits = 0; req_int_payload = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed corners: zeros, denormal, below one, limits, NaN, infinity
      special = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
                  64'h3fef_ffff_ffff_ffff, dbl(1, 1023, 52'h8_0000_0000_0000),
                  dbl(0, 1023 + 31, 0), dbl(1, 1023 + 31, 0), dbl(0, 1023 + 32, 52'h1),
                  dbl(0, 1023 + 63, 0), dbl(1, 1023 + 63, 0),
                  dbl(0, 1023 + 62, 52'hf_ffff_ffff_ffff), dbl(0, 1023 + 116, 52'h1),
                  dbl(0, 1023 + 117, 52'h1), dbl(0, 2047, 0), dbl(1, 2047, 0),
                  dbl(0, 2047, 52'h1), 64'hffff_ffff_ffff_ffff, 64'h7fef_ffff_ffff_ffff};
      foreach (special[i])
         for (int m = 0; m < 4; m++) send(2'(m), d2i_pkg::TAG_FLOAT, special[i], 32'h0);
      send(d2i_pkg::FUNC_I32, d2i_pkg::TAG_INT, 64'h0, 32'h8000_0000);
      send(FUNC_I64_SAT, d2i_pkg::TAG_INT, 64'h0, 32'h7fff_ffff);
      send(FUNC_I64_WRAP, TAG_EXC, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
      send(FUNC_I64_WRAP, TAG_SPARE, 64'h1, 32'h1);
      req_valid <= 1'b0;

      // sender pauses until every expected response has arrived
      while (sb.value_q.size() != 0) @(posedge clock);
      @(negedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 400) hold_off_req = 1;
         f = $urandom_range(0, 7) == 0 ? FUNC_SPARE : 2'($urandom_range(0, 2));
         t = $urandom_range(0, 9) < 6 ? d2i_pkg::TAG_FLOAT
           : ($urandom_range(0, 4) == 0 ? 2'($urandom_range(2, 3)) : d2i_pkg::TAG_INT);
         send(f, t, t == d2i_pkg::TAG_FLOAT ? random_double() : {$urandom, $urandom},
              $urandom);
      end
      req_valid <= 1'b0;
      stimulus_done = 1;
   end

   // finish once all responses are in, or at the cycle limit
   initial begin
      while (!(stimulus_done && sb.value_q.size() == 0) && cycles < LIMIT_CYCLES)
         @(posedge clock);
      if (cycles >= LIMIT_CYCLES) begin
         $display("Some tests failed");
      end else begin
         repeat (10) @(posedge clock);
         if (sb.fails == 0 && sb.value_q.size() == 0) begin
            $display("All tests passed");
         end else begin
            $display("Some tests failed");
         end
      end
      $finish;
   end
endmodule

### files.f
hdl/d2i_pkg.sv
hdl/double_to_integer_converter.sv
dv/double_to_integer_converter_tb.sv
